// ===== hw/rtl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the classification confusion counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // Command carried in the input tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Threshold register indexes on the configuration port
  localparam int            NUM_THRESH = 3;
  localparam int            CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2 = 2'd2;

  // Threshold reset values, signed Q16.16
  localparam logic signed [31:0] THRESHOLD_0_RST = 32'sd0;
  localparam logic signed [31:0] THRESHOLD_1_RST = 32'sd65536;
  localparam logic signed [31:0] THRESHOLD_2_RST = 32'sd131072;

  // Scores carried per sample word
  localparam int NUM_SCORES = 4;
  localparam int SCORE_W    = 16;

  // Stream word widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 136;

  // Output queue depth, words
  localparam int OQ_DEPTH = 3;

  // One result word
  typedef struct packed {
    logic [31:0] class_errors;
    logic [31:0] class_count;
    logic [31:0] conf_count;
    logic [31:0] total_errors;
    logic        mismatch;
    logic [1:0]  pred_class;
    logic        pred_valid;
    logic [1:0]  true_class;
  } result_t;

endpackage

// ===== hw/rtl/ccc_ram.sv =====
// ----------------------------------------------------------------------------
// ccc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/classification_confusion_counter_top.sv =====
// ----------------------------------------------------------------------------
// classification_confusion_counter_top
// Scores classified time steps into a confusion matrix and error counters.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle while the output queue has room. A word
// passes two stages: the first quantizes the target, finds the argmax of the
// scores and issues the counter RAM reads; the second updates the counters and
// writes them back, with forwarding of the previous cycle's write so that
// back-to-back words on the same entry count correctly. Results leave through
// a three-word queue after the stage 1 register; the input keeps flowing while
// the output is stalled until queue and stage 1 together hold three words. The
// figure of one word per cycle is set by the single read-modify-write of each
// counter RAM. After reset every counter reads zero at once (per-entry valid
// flags); there is no clearing pass. Counters saturate at all ones.
// ----------------------------------------------------------------------------
module classification_confusion_counter_top #(
  parameter int NUM_CLASSES = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: target_value[31:0], score_a[47:32], score_b[63:48], score_c[79:64],
  //        score_d[95:80], read_pred[97:96], read_true[99:98], zero fill
  input  logic [ccc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // tuser: cmd
  input  logic                                 s_axis_tuser,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: true_class[1:0], pred_valid[2], pred_class[4:3], mismatch[5],
  //        total_errors[37:6], conf_count[69:38], class_count[101:70],
  //        class_errors[133:102], zero fill
  output logic [ccc_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  localparam int CONF_DEPTH = NUM_CLASSES * NUM_CLASSES;
  localparam int CONF_AW    = $clog2(CONF_DEPTH);
  localparam int CLS_AW     = $clog2(NUM_CLASSES);
  localparam int THR_USED   = (NUM_CLASSES - 1 < ccc_pkg::NUM_THRESH) ?
                              NUM_CLASSES - 1 : ccc_pkg::NUM_THRESH;
  localparam int SCORE_USED = (NUM_CLASSES < ccc_pkg::NUM_SCORES) ?
                              NUM_CLASSES : ccc_pkg::NUM_SCORES;
  localparam int OQ_PW      = $clog2(ccc_pkg::OQ_DEPTH);
  localparam int OQ_CW      = $clog2(ccc_pkg::OQ_DEPTH + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // Stage 1 control word
  typedef struct packed {
    logic               cmd;
    logic [1:0]         true_class;
    logic               pred_valid;
    logic [1:0]         pred_class;
    logic               mismatch;
    logic               conf_ok;
    logic               cls_ok;
    logic [CONF_AW-1:0] conf_addr;
    logic [CLS_AW-1:0]  cls_addr;
  } s1_t;

  // --------------------------------------------------------------------------
  // Threshold registers
  logic signed [31:0] thr [ccc_pkg::NUM_THRESH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr[0] <= ccc_pkg::THRESHOLD_0_RST;
      thr[1] <= ccc_pkg::THRESHOLD_1_RST;
      thr[2] <= ccc_pkg::THRESHOLD_2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccc_pkg::REG_THRESHOLD_0: thr[0] <= cfg_data;
        ccc_pkg::REG_THRESHOLD_1: thr[1] <= cfg_data;
        ccc_pkg::REG_THRESHOLD_2: thr[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: classify and issue reads
  logic               in_fire;
  logic signed [31:0] target;
  logic [1:0]         read_pred;
  logic [1:0]         read_true;
  logic [ccc_pkg::SCORE_W-1:0] score [ccc_pkg::NUM_SCORES];
  logic [ccc_pkg::SCORE_W-1:0] best;
  logic [1:0]         tc;
  logic [1:0]         pc;
  logic               pv;
  s1_t                s0;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign target    = $signed(s_axis_tdata[31:0]);
  assign score[0]  = s_axis_tdata[47:32];
  assign score[1]  = s_axis_tdata[63:48];
  assign score[2]  = s_axis_tdata[79:64];
  assign score[3]  = s_axis_tdata[95:80];
  assign read_pred = s_axis_tdata[97:96];
  assign read_true = s_axis_tdata[99:98];

  // threshold compare
  always_comb begin
    tc = 2'd0;
    for (int y = 0; y < THR_USED; y++) begin
      if (target > thr[y]) begin
        tc = 2'(y + 1);
      end
    end
  end

  // argmax, strictly greater, from a running best of zero
  always_comb begin
    best = '0;
    pc   = 2'd0;
    pv   = 1'b0;
    for (int c = 0; c < SCORE_USED; c++) begin
      if (score[c] > best) begin
        best = score[c];
        pc   = 2'(c);
        pv   = 1'b1;
      end
    end
  end

  // addresses and flags for stage 1
  always_comb begin
    s0.cmd        = s_axis_tuser;
    s0.true_class = tc;
    s0.pred_valid = pv;
    s0.pred_class = pc;
    s0.mismatch   = !pv || (pc != tc);
    if (s_axis_tuser == ccc_pkg::CMD_READ) begin
      s0.cls_ok    = int'(read_true) < NUM_CLASSES;
      s0.conf_ok   = s0.cls_ok && (int'(read_pred) < NUM_CLASSES);
      s0.conf_addr = CONF_AW'(int'(read_pred) * NUM_CLASSES + int'(read_true));
      s0.cls_addr  = CLS_AW'(read_true);
    end else begin
      s0.cls_ok    = 1'b1;
      s0.conf_ok   = 1'b1;
      s0.conf_addr = CONF_AW'(int'(pc) * NUM_CLASSES + int'(tc));
      s0.cls_addr  = CLS_AW'(tc);
    end
  end

  // --------------------------------------------------------------------------
  // Counter RAMs: confusion matrix, and {class errors, class count} per class
  logic                     conf_we;
  count_t                   conf_wdata;
  count_t                   conf_rdata;
  logic                     cls_we;
  logic [2*COUNT_WIDTH-1:0] cls_wdata;
  logic [2*COUNT_WIDTH-1:0] cls_rdata;
  s1_t                      s1;
  logic                     s1_valid;

  ccc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CONF_DEPTH)
  ) u_conf_ram (
    .clk   (clk),
    .we    (conf_we),
    .waddr (s1.conf_addr),
    .wdata (conf_wdata),
    .raddr (s0.conf_addr),
    .rdata (conf_rdata)
  );

  ccc_ram #(
    .WIDTH (2 * COUNT_WIDTH),
    .DEPTH (NUM_CLASSES)
  ) u_cls_ram (
    .clk   (clk),
    .we    (cls_we),
    .waddr (s1.cls_addr),
    .wdata (cls_wdata),
    .raddr (s0.cls_addr),
    .rdata (cls_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1 register, entry valid flags, forwarding and running total
  logic [CONF_DEPTH-1:0]    conf_vld;
  logic [NUM_CLASSES-1:0]   cls_vld;
  logic                     fwd_conf_v;
  logic [CONF_AW-1:0]       fwd_conf_addr;
  count_t                   fwd_conf_data;
  logic                     fwd_cls_v;
  logic [CLS_AW-1:0]        fwd_cls_addr;
  logic [2*COUNT_WIDTH-1:0] fwd_cls_data;
  count_t                   err_total;
  count_t                   err_total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      conf_vld   <= '0;
      cls_vld    <= '0;
      fwd_conf_v <= 1'b0;
      fwd_cls_v  <= 1'b0;
      err_total  <= '0;
    end else begin
      s1_valid   <= in_fire;
      fwd_conf_v <= conf_we;
      fwd_cls_v  <= cls_we;
      err_total  <= err_total_next;
      if (conf_we) begin
        conf_vld[s1.conf_addr] <= 1'b1;
      end
      if (cls_we) begin
        cls_vld[s1.cls_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1            <= s0;
    fwd_conf_addr <= s1.conf_addr;
    fwd_conf_data <= conf_wdata;
    fwd_cls_addr  <= s1.cls_addr;
    fwd_cls_data  <= cls_wdata;
  end

  // read-modify-write
  count_t           conf_cur;
  count_t           cnt_cur;
  count_t           errc_cur;
  count_t           cnt_new;
  count_t           errc_new;
  ccc_pkg::result_t res;
  logic             sample;

  always_comb begin
    if (fwd_conf_v && (fwd_conf_addr == s1.conf_addr)) begin
      conf_cur = fwd_conf_data;
    end else if (conf_vld[s1.conf_addr]) begin
      conf_cur = conf_rdata;
    end else begin
      conf_cur = '0;
    end

    if (fwd_cls_v && (fwd_cls_addr == s1.cls_addr)) begin
      {errc_cur, cnt_cur} = fwd_cls_data;
    end else if (cls_vld[s1.cls_addr]) begin
      {errc_cur, cnt_cur} = cls_rdata;
    end else begin
      {errc_cur, cnt_cur} = '0;
    end

    sample     = s1_valid && (s1.cmd == ccc_pkg::CMD_SAMPLE);
    conf_wdata = sat_inc(conf_cur);
    cnt_new    = s1.pred_valid ? sat_inc(cnt_cur) : cnt_cur;
    errc_new   = s1.mismatch ? sat_inc(errc_cur) : errc_cur;
    cls_wdata  = {errc_new, cnt_new};
    conf_we    = sample && s1.pred_valid;
    cls_we     = sample;

    err_total_next = (sample && s1.mismatch) ? sat_inc(err_total) : err_total;

    // result word
    res = '0;
    if (s1.cmd == ccc_pkg::CMD_READ) begin
      res.total_errors = 32'(err_total);
      res.conf_count   = s1.conf_ok ? 32'(conf_cur) : 32'd0;
      res.class_count  = s1.cls_ok ? 32'(cnt_cur) : 32'd0;
      res.class_errors = s1.cls_ok ? 32'(errc_cur) : 32'd0;
    end else begin
      res.true_class   = s1.true_class;
      res.pred_valid   = s1.pred_valid;
      res.pred_class   = s1.pred_class;
      res.mismatch     = s1.mismatch;
      res.total_errors = 32'(err_total_next);
    end
  end

  // --------------------------------------------------------------------------
  // Output queue
  ccc_pkg::result_t oq [ccc_pkg::OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wr;
  logic [OQ_PW-1:0] oq_rd;
  logic [OQ_CW-1:0] oq_count;
  logic             oq_pop;

  assign oq_pop        = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = oq_count != '0;
  assign m_axis_tdata  = ccc_pkg::OUT_DATA_W'(oq[oq_rd]);

  // room for the word in stage 1 and one more
  assign s_axis_tready = (32'(oq_count) + 32'(s1_valid)) < ccc_pkg::OQ_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (s1_valid) begin
        oq_wr <= (32'(oq_wr) == ccc_pkg::OQ_DEPTH - 1) ? '0 : oq_wr + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rd <= (32'(oq_rd) == ccc_pkg::OQ_DEPTH - 1) ? '0 : oq_rd + OQ_PW'(1);
      end
      oq_count <= oq_count + OQ_CW'(s1_valid) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[oq_wr] <= res;
    end
  end

endmodule

// ===== sim/classification_confusion_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// classification_confusion_counter_top_tb
// Self-checking bench for the classification confusion counter.
// ----------------------------------------------------------------------------
// A short directed run covers the class boundaries, argmax ties, the case
// with no positive score and reads of every counter kind. Random runs then
// follow under six threshold settings, the extremes among them. Each run
// uses one of three stall settings on the two streams, the last with none. A tally
// object predicts each result word from the accepted input words and checks
// the output stream against it in order.
// ----------------------------------------------------------------------------
module classification_confusion_counter_top_tb;
  import ccc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_WORDS     = 75;

  // one input word, unpacked into its fields
  typedef struct packed {
    logic        cmd;
    logic [31:0] target;
    logic [15:0] score_a;
    logic [15:0] score_b;
    logic [15:0] score_c;
    logic [15:0] score_d;
    logic [1:0]  read_pred;
    logic [1:0]  read_true;
  } word_in_t;

  // Counter predictor and queue of result words still due
  class confusion_tally;
    logic [31:0] thresh [NUM_THRESH];
    logic [31:0] conf [4][4];
    logic [31:0] cls_count [4];
    logic [31:0] cls_errors [4];
    logic [31:0] err_total;
    result_t     due_results [$];
    int          n_mismatch;
    int          n_checked;
    int          n_samples;
    int          n_reads;

    function new();
      thresh[0] = THRESHOLD_0_RST;
      thresh[1] = THRESHOLD_1_RST;
      thresh[2] = THRESHOLD_2_RST;
      for (int i = 0; i < 4; i++) begin
        cls_count[i]  = '0;
        cls_errors[i] = '0;
        for (int j = 0; j < 4; j++) conf[i][j] = '0;
      end
      err_total  = '0;
      n_mismatch = 0;
      n_checked  = 0;
      n_samples  = 0;
      n_reads    = 0;
    endfunction

    // saturating increment
    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx < NUM_THRESH) thresh[idx] = value;
    endfunction

    // Note one accepted input word and queue the result it causes
    function void score_word(word_in_t w);
      result_t     r;
      logic [15:0] sc [4];
      logic [15:0] best;
      logic [1:0]  tc;
      logic [1:0]  pc;
      bit          valid;
      bit          miss;
      r = '0;
      if (w.cmd == CMD_READ) begin
        r.total_errors = err_total;
        r.conf_count   = conf[w.read_pred][w.read_true];
        r.class_count  = cls_count[w.read_true];
        r.class_errors = cls_errors[w.read_true];
        n_reads++;
      end else begin
        sc[0] = w.score_a;
        sc[1] = w.score_b;
        sc[2] = w.score_c;
        sc[3] = w.score_d;
        // quantize: last threshold, in index order, strictly exceeded
        tc = 2'd0;
        for (int y = 0; y < NUM_THRESH; y++)
          if ($signed(w.target) > $signed(thresh[y])) tc = 2'(y + 1);
        // strict-greater argmax from a running best of zero
        best  = '0;
        valid = 1'b0;
        pc    = 2'd0;
        for (int c = 0; c < 4; c++)
          if (sc[c] > best) begin
            best  = sc[c];
            pc    = 2'(c);
            valid = 1'b1;
          end
        miss = !valid || (pc != tc);
        if (miss) begin
          err_total      = bump(err_total);
          cls_errors[tc] = bump(cls_errors[tc]);
        end
        if (valid) begin
          conf[pc][tc]  = bump(conf[pc][tc]);
          cls_count[tc] = bump(cls_count[tc]);
        end
        r.true_class   = tc;
        r.pred_valid   = valid;
        r.pred_class   = pc;
        r.mismatch     = miss;
        r.total_errors = err_total;
        n_samples++;
      end
      due_results.push_back(r);
    endfunction

    // Compare one output word with the oldest result due
    function void check_result(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[$bits(result_t)-1:0]);
      n_checked++;
      if (due_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: output word %h with none due", word);
        return;
      end
      want = due_results.pop_front();
      if (got.true_class !== want.true_class || got.pred_valid !== want.pred_valid ||
          got.pred_class !== want.pred_class || got.mismatch !== want.mismatch ||
          got.total_errors !== want.total_errors || got.conf_count !== want.conf_count ||
          got.class_count !== want.class_count ||
          got.class_errors !== want.class_errors) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("ERROR: result %0d differs (cls/pv/pc/mis/total/conf/count/errs)",
                   n_checked);
          $display("  exp %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d", want.true_class,
                   want.pred_valid, want.pred_class, want.mismatch, want.total_errors,
                   want.conf_count, want.class_count, want.class_errors);
          $display("  got %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d", got.true_class,
                   got.pred_valid, got.pred_class, got.mismatch, got.total_errors,
                   got.conf_count, got.class_count, got.class_errors);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [31:0]                cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_DATA_W-1:0]       s_axis_tdata;
  logic                       s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [OUT_DATA_W-1:0]      m_axis_tdata;

  confusion_tally book;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             cycle_count = 0;
  logic [31:0]    cur_thresh [NUM_THRESH];

  classification_confusion_counter_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random back-pressure, check every accepted word
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);

  function automatic word_in_t mk_sample(logic [31:0] target, logic [15:0] a,
                                         logic [15:0] b, logic [15:0] c, logic [15:0] d);
    word_in_t w;
    w.cmd       = CMD_SAMPLE;
    w.target    = target;
    w.score_a   = a;
    w.score_b   = b;
    w.score_c   = c;
    w.score_d   = d;
    w.read_pred = 2'($urandom);
    w.read_true = 2'($urandom);
    return w;
  endfunction

  function automatic word_in_t mk_read(logic [1:0] rp, logic [1:0] rt);
    word_in_t w;
    w = mk_sample($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    w.cmd       = CMD_READ;
    w.read_pred = rp;
    w.read_true = rt;
    return w;
  endfunction

  // Random word: targets mostly cluster round the thresholds, scores in several shapes
  function automatic word_in_t random_word();
    word_in_t    w;
    logic [31:0] tgt;
    logic [15:0] sc [4];
    logic [15:0] v;
    int          k;
    case ($urandom_range(3))
      0:       tgt = $urandom;
      3: begin
        case ($urandom_range(3))
          0:       tgt = 32'h8000_0000;
          1:       tgt = 32'h7FFF_FFFF;
          2:       tgt = 32'h0000_0000;
          default: tgt = 32'hFFFF_FFFF;
        endcase
      end
      default: tgt = cur_thresh[$urandom_range(NUM_THRESH - 1)]
                     + 32'($urandom_range(4)) - 32'd2;
    endcase
    for (int i = 0; i < 4; i++) sc[i] = 16'($urandom);
    k = $urandom_range(3);
    case ($urandom_range(5))
      1: for (int i = 0; i < 4; i++) sc[i] = '0;
      2: begin
        // one clear winner
        for (int i = 0; i < 4; i++) sc[i] = sc[i] >> 1;
        sc[k] = 16'hFFFF - 16'($urandom_range(15));
      end
      3: begin
        // the same score in up to three places, often a tie between classes
        v = 16'($urandom);
        sc[k] = v;
        sc[$urandom_range(3)] = v;
        if ($urandom_range(1)) sc[$urandom_range(3)] = v;
      end
      4: for (int i = 0; i < 4; i++) sc[i] = 16'($urandom_range(3));
      5: begin
        for (int i = 0; i < 4; i++) sc[i] = '0;
        sc[k] = 16'($urandom_range(1, 65535));
      end
      default: ;
    endcase
    w = mk_sample(tgt, sc[0], sc[1], sc[2], sc[3]);
    if ($urandom_range(99) < 20) w.cmd = CMD_READ;
    return w;
  endfunction

  // Offer one word on the input stream, with an optional gap before it
  task automatic send_word(word_in_t w);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.cmd;
    s_axis_tdata  <= {4'b0, w.read_true, w.read_pred, w.score_d, w.score_c,
                      w.score_b, w.score_a, w.target};
    do @(posedge clk); while (!s_axis_tready);
    book.score_word(w);
  endtask

  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    book.set_threshold(idx, value);
    cur_thresh[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering words and let every due result come out
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    book          = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    cur_thresh[0] = THRESHOLD_0_RST;
    cur_thresh[1] = THRESHOLD_1_RST;
    cur_thresh[2] = THRESHOLD_2_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset thresholds (0.0, 1.0, 2.0)
    send_word(mk_read(2'd0, 2'd0));
    send_word(mk_sample(32'h0000_0000, 16'hFFFF, 16'h0, 16'h0, 16'h0)); // at boundary
    send_word(mk_sample(32'h0000_0001, 16'h0, 16'hFFFF, 16'h0, 16'h0));
    send_word(mk_sample(32'h0001_0000, 16'h0, 16'h0, 16'hFFFF, 16'h0)); // equal, not above
    send_word(mk_sample(32'h0001_0001, 16'h0, 16'h0, 16'hFFFF, 16'h0));
    send_word(mk_sample(32'h0002_0000, 16'h1, 16'h2, 16'h3, 16'h4));
    send_word(mk_sample(32'h0002_0001, 16'h0, 16'h0, 16'h0, 16'h1));
    send_word(mk_sample(32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0));   // no prediction
    send_word(mk_sample(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // tie
    send_word(mk_sample(32'hFFFF_FFFF, 16'h1, 16'h7, 16'h7, 16'h2));
    send_word(mk_sample(32'h0001_8000, 16'h0, 16'h8000, 16'h8000, 16'h8000));
    send_word(mk_sample(32'h0000_0000, 16'h0, 16'h0, 16'h0, 16'h0));
    send_word(mk_sample(32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    send_word(mk_read(2'd3, 2'd3));
    send_word(mk_read(2'd2, 2'd1));
    send_word(mk_read(2'd0, 2'd3));
    send_word(mk_read(2'd3, 2'd0));
    send_word(mk_read(2'd1, 2'd0));
    send_word(mk_read(2'd2, 2'd2));
    drain_results();

    // Random runs, one threshold setting each
    for (int run = 1; run <= 6; run++) begin
      case ((run - 1) / 2)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 60;
        end
        1: begin
          tx_idle_pct = 60;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (run)
        1: begin
          write_threshold(REG_THRESHOLD_0, 32'h8000_0000);
          write_threshold(REG_THRESHOLD_1, 32'h8000_0000);
          write_threshold(REG_THRESHOLD_2, 32'h8000_0000);
        end
        2: begin
          write_threshold(REG_THRESHOLD_0, 32'h7FFF_FFFF);
          write_threshold(REG_THRESHOLD_1, 32'h7FFF_FFFF);
          write_threshold(REG_THRESHOLD_2, 32'h7FFF_FFFF);
        end
        3: begin
          // -1.5, 0.25, 3.0
          write_threshold(REG_THRESHOLD_0, 32'hFFFE_8000);
          write_threshold(REG_THRESHOLD_1, 32'h0000_4000);
          write_threshold(REG_THRESHOLD_2, 32'h0003_0000);
        end
        4: begin
          // out of order: later boundaries below earlier ones
          write_threshold(REG_THRESHOLD_0, 32'h0003_0000);
          write_threshold(REG_THRESHOLD_1, 32'hFFFF_0000);
          write_threshold(REG_THRESHOLD_2, 32'h0000_8000);
        end
        5: begin
          write_threshold(REG_THRESHOLD_0, $urandom);
          write_threshold(REG_THRESHOLD_1, $urandom);
          write_threshold(REG_THRESHOLD_2, $urandom);
        end
        default: begin
          write_threshold(REG_THRESHOLD_0, THRESHOLD_0_RST);
          write_threshold(REG_THRESHOLD_1, THRESHOLD_1_RST);
          write_threshold(REG_THRESHOLD_2, THRESHOLD_2_RST);
        end
      endcase
      for (int n = 0; n < RUN_WORDS; n++) send_word(random_word());
      drain_results();
    end

    $display("Covered %0d sample words and %0d counter reads under seven threshold settings",
             book.n_samples, book.n_reads);
    $display("%0d result words checked with stalls on either side, %0d mismatches",
             book.n_checked, book.n_mismatch);
    if (book.n_mismatch == 0 && book.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_ram.sv
hw/rtl/classification_confusion_counter_top.sv
sim/classification_confusion_counter_top_tb.sv
